// ----- rtl/core/header_checksum_frame_receiver_unit_assert.svh -----
// Assertion macros shared by the frame receiver modules.
// Each expects clk_i and rst_ni to be visible in the module that uses it.
`ifndef HEADER_CHECKSUM_FRAME_RECEIVER_UNIT_ASSERT_SVH
`define HEADER_CHECKSUM_FRAME_RECEIVER_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define HCFR_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define HCFR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/hcfr_pkg.sv -----
`timescale 1ns / 1ps

package hcfr_pkg;

  localparam int unsigned MaxFrameDefault = 16;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 8;

  localparam logic [CfgIdxW-1:0] REG_HEADER_LENGTH    = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_HEADER_FIRST     = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_HEADER_SECOND    = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_HEADER_THIRD     = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_FRAME_LENGTH     = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_HOLD_ON_MISMATCH = 3'd5;

  localparam logic [1:0] ACT_RECEIVE = 2'd0;
  localparam logic [1:0] ACT_READ    = 2'd1;
  localparam logic [1:0] ACT_RELEASE = 2'd2;

  typedef enum logic [2:0] {
    ST_SKIPPED  = 3'd0,
    ST_ACCEPTED = 3'd1,
    ST_GOOD     = 3'd2,
    ST_BAD      = 3'd3,
    ST_IGNORED  = 3'd4,
    ST_RELEASED = 3'd5,
    ST_READ     = 3'd6
  } status_e;

  typedef struct packed {
    logic [1:0] header_length;
    logic [7:0] header_first;
    logic [7:0] header_second;
    logic [7:0] header_third;
    logic [4:0] frame_length;
    logic       hold_on_mismatch;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    header_length:    2'd3,
    header_first:     8'd64,
    header_second:    8'd94,
    header_third:     8'd118,
    frame_length:     5'd10,
    hold_on_mismatch: 1'b0
  };

  typedef struct packed {
    status_e    status;
    logic [4:0] byte_count;
    logic       frame_ready;
  } result_t;

  typedef struct packed {
    logic       en;
    logic [4:0] pos;
    logic [7:0] data;
  } store_wr_t;

endpackage

// ----- rtl/core/header_checksum_frame_receiver_unit.sv -----
`timescale 1ns / 1ps

// Channel   Direction  Handshake                  Payload
// in        input      in_valid_i / in_ready_o    action_i, data_byte_i, read_index_i
// out       output     out_valid_o / out_ready_i  status_o, byte_count_o, frame_ready_o,
//                                                 read_data_o
// cfg       input      cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// One item per cycle while results are taken; each result appears in the cycle after
// its transfer, together with the registered read of the frame store.
// A result waiting in the output register stalls the input; a new item enters in
// the cycle that the waiting result is taken.
// Reset clears position, sum, held flag, config and out_valid; the store is not cleared.
// Configuration writes are always taken.

`include "header_checksum_frame_receiver_unit_assert.svh"

module header_checksum_frame_receiver_unit #(
  parameter int unsigned MaxFrame = hcfr_pkg::MaxFrameDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [hcfr_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [hcfr_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    action_i,
  input  logic [7:0]                    data_byte_i,
  input  logic [3:0]                    read_index_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [2:0]                    status_o,
  output logic [4:0]                    byte_count_o,
  output logic                          frame_ready_o,
  output logic [7:0]                    read_data_o
);

  import hcfr_pkg::*;

  localparam int unsigned AddrW = $clog2(MaxFrame);

  cfg_t      cfg;
  result_t   result;
  store_wr_t store_wr;
  logic      accept;
  logic      rd_hit;
  logic [7:0] rdata;

  logic      out_valid_d, out_valid_q;
  result_t   res_q;
  logic      rd_hit_q;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign rd_hit      = (action_i == ACT_READ) && (32'(read_index_i) < MaxFrame);

  hcfr_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  hcfr_ctrl #(
    .MaxFrame (MaxFrame)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .accept_i    (accept),
    .action_i    (action_i),
    .data_byte_i (data_byte_i),
    .result_o    (result),
    .store_wr_o  (store_wr)
  );

  // Each transfer either writes or reads the store, never both, so a read
  // always sees every earlier write.
  hcfr_ram #(
    .Width (8),
    .Depth (MaxFrame)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (store_wr.en),
    .waddr_i (AddrW'(store_wr.pos)),
    .wdata_i (store_wr.data),
    .re_i    (accept && rd_hit),
    .raddr_i (AddrW'(read_index_i)),
    .rdata_o (rdata)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q    <= result;
      rd_hit_q <= rd_hit && accept;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = res_q.status;
  assign byte_count_o  = res_q.byte_count;
  assign frame_ready_o = res_q.frame_ready;
  assign read_data_o   = rd_hit_q ? rdata : 8'd0;

  `HCFR_ASSERT_NEXT(a_transfer_gives_result, accept, out_valid_o, "Accepted item produced no result")
  `HCFR_ASSERT(a_read_data_only_on_read, out_valid_o && (res_q.status != ST_READ), read_data_o == 8'd0, "Read data on a non-read result")
  `HCFR_ASSERT(a_ready_has_count, out_valid_o && frame_ready_o, byte_count_o != 5'd0, "Held frame reported with zero count")

endmodule

// ----- rtl/core/hcfr_ram.sv -----
`timescale 1ns / 1ps

module hcfr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read data holds until the next read, so a stalled consumer keeps it.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/hcfr_cfg.sv -----
`timescale 1ns / 1ps

module hcfr_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic [hcfr_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [hcfr_pkg::CfgDataW-1:0] cfg_data_i,
  output hcfr_pkg::cfg_t                cfg_o
);

  import hcfr_pkg::*;

  cfg_t cfg_d, cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_HEADER_LENGTH:    cfg_d.header_length    = cfg_data_i[1:0];
        REG_HEADER_FIRST:     cfg_d.header_first     = cfg_data_i;
        REG_HEADER_SECOND:    cfg_d.header_second    = cfg_data_i;
        REG_HEADER_THIRD:     cfg_d.header_third     = cfg_data_i;
        REG_FRAME_LENGTH:     cfg_d.frame_length     = cfg_data_i[4:0];
        REG_HOLD_ON_MISMATCH: cfg_d.hold_on_mismatch = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- rtl/core/hcfr_ctrl.sv -----
`timescale 1ns / 1ps

`include "header_checksum_frame_receiver_unit_assert.svh"

module hcfr_ctrl #(
  parameter int unsigned MaxFrame = hcfr_pkg::MaxFrameDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  hcfr_pkg::cfg_t      cfg_i,
  input  logic                accept_i,
  input  logic [1:0]          action_i,
  input  logic [7:0]          data_byte_i,
  output hcfr_pkg::result_t   result_o,
  output hcfr_pkg::store_wr_t store_wr_o
);

  import hcfr_pkg::*;

  // Position never exceeds what frame_length can express.
  localparam int unsigned LenCap = (MaxFrame > 31) ? 31 : MaxFrame;

  logic [4:0] pos_d, pos_q;
  logic [7:0] sum_d, sum_q;
  logic       held_d, held_q;

  logic [4:0] eff_len;
  logic [4:0] pos_eff;
  logic [7:0] expected;
  logic       hdr_bad;
  logic       last_byte;
  status_e    status;

  always_comb begin
    if (cfg_i.frame_length == 5'd0) begin
      eff_len = 5'd1;
    end else if (32'(cfg_i.frame_length) > LenCap) begin
      eff_len = 5'(LenCap);
    end else begin
      eff_len = cfg_i.frame_length;
    end
  end

  // A length change that leaves the position at or beyond the new length restarts at the front.
  assign pos_eff = (pos_q >= eff_len) ? 5'd0 : pos_q;

  always_comb begin
    if (pos_eff == 5'd0) begin
      expected = cfg_i.header_first;
    end else if (pos_eff == 5'd1) begin
      expected = cfg_i.header_second;
    end else begin
      expected = cfg_i.header_third;
    end
  end

  assign hdr_bad   = ({3'b000, cfg_i.header_length} > pos_eff) && (pos_eff < 5'd3)
                     && (data_byte_i != expected);
  assign last_byte = ((pos_eff + 5'd1) == eff_len);

  always_comb begin
    pos_d           = pos_q;
    sum_d           = sum_q;
    held_d          = held_q;
    status          = ST_SKIPPED;
    store_wr_o.en   = 1'b0;
    store_wr_o.pos  = pos_eff;
    store_wr_o.data = data_byte_i;
    if (accept_i) begin
      case (action_i)
        ACT_RECEIVE: begin
          if (held_q) begin
            status = ST_IGNORED;
          end else begin
            // Every byte taken is stored, a skipped header byte too.
            store_wr_o.en = 1'b1;
            pos_d         = pos_eff;
            if (hdr_bad) begin
              if ((pos_eff != 5'd0) && !cfg_i.hold_on_mismatch) begin
                pos_d = 5'd0;
                sum_d = 8'd0;
              end
            end else if (last_byte) begin
              if (data_byte_i == sum_q) begin
                held_d = 1'b1;
                pos_d  = eff_len;
                status = ST_GOOD;
              end else begin
                pos_d  = 5'd0;
                sum_d  = 8'd0;
                status = ST_BAD;
              end
            end else begin
              sum_d  = sum_q + data_byte_i;
              pos_d  = pos_eff + 5'd1;
              status = ST_ACCEPTED;
            end
          end
        end
        ACT_READ: begin
          status = ST_READ;
        end
        ACT_RELEASE: begin
          if (held_q) begin
            held_d = 1'b0;
            pos_d  = 5'd0;
            sum_d  = 8'd0;
            status = ST_RELEASED;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= 5'd0;
      sum_q  <= 8'd0;
      held_q <= 1'b0;
    end else begin
      pos_q  <= pos_d;
      sum_q  <= sum_d;
      held_q <= held_d;
    end
  end

  assign result_o.status      = status;
  assign result_o.byte_count  = pos_d;
  assign result_o.frame_ready = held_d;

  `HCFR_ASSERT_NEXT(a_held_ignores_bytes, accept_i && held_q && (action_i == ACT_RECEIVE), held_q && $stable(pos_q), "Received byte disturbed a held frame")
  `HCFR_ASSERT(a_no_store_while_held, store_wr_o.en, !held_q, "Store written while a frame is held")
  `HCFR_ASSERT(a_held_position, held_q, pos_q != 5'd0, "Held frame with zero position")

endmodule

// ----- verif/hcfr_frame_check.sv -----
`timescale 1ns / 1ps

module hcfr_frame_check
  import hcfr_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  logic [1:0]          action_i,
  input  logic [7:0]          data_byte_i,
  input  logic [3:0]          read_index_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  logic [2:0]          status_i,
  input  logic [4:0]          byte_count_i,
  input  logic                frame_ready_i,
  input  logic [7:0]          read_data_i,
  output int                  fail_count_o,
  output int                  pending_o,
  output logic [4:0]          frame_pos_o,
  output logic [7:0]          frame_sum_o,
  output logic                frame_held_o
);

  typedef struct {
    status_e    status;
    logic [4:0] byte_count;
    logic       frame_ready;
    logic [7:0] read_data;
  } frame_result_t;

  cfg_t          cfg_q;
  logic [7:0]    frame_bytes [MaxFrameDefault];
  logic [4:0]    cur_pos;
  logic [7:0]    cur_sum;
  logic          frame_held;
  frame_result_t frame_results_q [$];
  int            mismatches;

  assign fail_count_o = mismatches;
  assign pending_o    = frame_results_q.size();
  assign frame_pos_o  = cur_pos;
  assign frame_sum_o  = cur_sum;
  assign frame_held_o = frame_held;

  // Applies one transfer to the frame state and returns the result it must produce.
  function automatic frame_result_t advance_frame(logic [1:0] act, logic [7:0] b,
                                                  logic [3:0] idx);
    frame_result_t r;
    int unsigned   span;
    logic [7:0]    hdr;
    span = 32'(cfg_q.frame_length);
    if (span < 1) span = 1;
    if (span > MaxFrameDefault) span = MaxFrameDefault;
    r.status    = ST_SKIPPED;
    r.read_data = 8'h00;
    case (act)
      ACT_RECEIVE: begin
        if (frame_held) begin
          r.status = ST_IGNORED;
        end else begin
          if (cur_pos >= span) cur_pos = '0;
          frame_bytes[cur_pos[3:0]] = b;
          hdr = (cur_pos == 0) ? cfg_q.header_first :
                (cur_pos == 1) ? cfg_q.header_second : cfg_q.header_third;
          if (cur_pos < cfg_q.header_length && cur_pos < 3 && b != hdr) begin
            if (cur_pos != 0 && !cfg_q.hold_on_mismatch) begin
              cur_pos = '0;
              cur_sum = '0;
            end
          end else if (cur_pos + 1 == span) begin
            if (b == cur_sum) begin
              frame_held = 1'b1;
              cur_pos    = 5'(span);
              r.status   = ST_GOOD;
            end else begin
              cur_pos  = '0;
              cur_sum  = '0;
              r.status = ST_BAD;
            end
          end else begin
            cur_sum  = cur_sum + b;
            cur_pos  = cur_pos + 5'd1;
            r.status = ST_ACCEPTED;
          end
        end
      end
      ACT_READ: begin
        r.status    = ST_READ;
        r.read_data = frame_bytes[idx];
      end
      ACT_RELEASE: begin
        if (frame_held) begin
          frame_held = 1'b0;
          cur_pos    = '0;
          cur_sum    = '0;
          r.status   = ST_RELEASED;
        end
      end
      default: ;
    endcase
    r.byte_count  = cur_pos;
    r.frame_ready = frame_held;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    frame_result_t want;
    if (!rst_ni) begin
      cfg_q      = CfgReset;
      cur_pos    = '0;
      cur_sum    = '0;
      frame_held = 1'b0;
      mismatches = 0;
      foreach (frame_bytes[i]) frame_bytes[i] = 8'h00;
      frame_results_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_HEADER_LENGTH:    cfg_q.header_length    = cfg_data_i[1:0];
          REG_HEADER_FIRST:     cfg_q.header_first     = cfg_data_i;
          REG_HEADER_SECOND:    cfg_q.header_second    = cfg_data_i;
          REG_HEADER_THIRD:     cfg_q.header_third     = cfg_data_i;
          REG_FRAME_LENGTH:     cfg_q.frame_length     = cfg_data_i[4:0];
          REG_HOLD_ON_MISMATCH: cfg_q.hold_on_mismatch = cfg_data_i[0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        frame_results_q.push_back(advance_frame(action_i, data_byte_i, read_index_i));
      end
      if (out_valid_i && out_ready_i) begin
        if (frame_results_q.size() == 0) begin
          if (mismatches < 10) begin
            $display("%0t: unexpected result: status %0d count %0d ready %0b data %02h",
                     $realtime, status_i, byte_count_i, frame_ready_i, read_data_i);
          end
          mismatches++;
        end else begin
          want = frame_results_q.pop_front();
          if (status_i !== want.status || byte_count_i !== want.byte_count ||
              frame_ready_i !== want.frame_ready || read_data_i !== want.read_data) begin
            if (mismatches < 10) begin
              $display("%0t: mismatch: status %0d/%0d count %0d/%0d ready %0b/%0b data %02h/%02h",
                       $realtime, want.status, status_i, want.byte_count, byte_count_i,
                       want.frame_ready, frame_ready_i, want.read_data, read_data_i);
            end
            mismatches++;
          end
        end
      end
    end
  end

endmodule

// ----- verif/tb_header_checksum_frame_receiver_unit.sv -----
`timescale 1ns / 1ps

module tb_header_checksum_frame_receiver_unit;
  import hcfr_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned PhaseItems = 105;
  localparam int unsigned HoldOffCycles = 80;

  localparam logic [CfgIdxW-1:0] RegSpareLo = 3'd6;
  localparam logic [CfgIdxW-1:0] RegSpareHi = 3'd7;
  localparam logic [1:0]         ActNone    = 2'd3;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [1:0]          action_i;
  logic [7:0]          data_byte_i;
  logic [3:0]          read_index_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [2:0]          status_o;
  logic [4:0]          byte_count_o;
  logic                frame_ready_o;
  logic [7:0]          read_data_o;

  int          fail_count;
  int          pending;
  logic [4:0]  pred_pos;
  logic [7:0]  pred_sum;
  logic        pred_held;

  bit          no_gaps;
  bit          hold_off_req;
  int unsigned items_sent;
  int unsigned cycle_cnt;

  // Register values last written, used to build frames the receiver will take.
  logic [1:0]  hdr_len;
  logic [7:0]  hdr_byte [3];
  logic [4:0]  frm_len;

  header_checksum_frame_receiver_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .action_i      (action_i),
    .data_byte_i   (data_byte_i),
    .read_index_i  (read_index_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .byte_count_o  (byte_count_o),
    .frame_ready_o (frame_ready_o),
    .read_data_o   (read_data_o)
  );

  hcfr_frame_check u_frame_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_i   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .action_i      (action_i),
    .data_byte_i   (data_byte_i),
    .read_index_i  (read_index_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_i      (status_o),
    .byte_count_i  (byte_count_o),
    .frame_ready_i (frame_ready_o),
    .read_data_i   (read_data_o),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .frame_pos_o   (pred_pos),
    .frame_sum_o   (pred_sum),
    .frame_held_o  (pred_held)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("== FAIL ==");
    $finish;
  end

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        out_ready_i <= 1'b0;
        repeat (HoldOffCycles) @(negedge clk_i);
        hold_off_req = 1'b0;
      end else begin
        out_ready_i <= no_gaps || ($urandom_range(99) >= 11);
      end
    end
  end

  task automatic send_item(input logic [1:0] act, input logic [7:0] b, input logic [3:0] idx);
    if (!no_gaps) begin
      while ($urandom_range(99) < 11) begin
        in_valid_i <= 1'b0;
        @(negedge clk_i);
      end
    end
    in_valid_i   <= 1'b1;
    action_i     <= act;
    data_byte_i  <= b;
    read_index_i <= idx;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    items_sent++;
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [7:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
    case (idx)
      REG_HEADER_LENGTH: hdr_len     = value[1:0];
      REG_HEADER_FIRST:  hdr_byte[0] = value;
      REG_HEADER_SECOND: hdr_byte[1] = value;
      REG_HEADER_THIRD:  hdr_byte[2] = value;
      REG_FRAME_LENGTH:  frm_len     = value[4:0];
      default: ;
    endcase
  endtask

  // Unused upper data bits are randomized; the block must drop them.
  task automatic apply_setting(input logic [1:0] hl, input logic [7:0] h0, input logic [7:0] h1,
                               input logic [7:0] h2, input logic [4:0] len, input logic hold);
    settle();
    write_reg(REG_HEADER_LENGTH, {6'($urandom), hl});
    write_reg(REG_HEADER_FIRST, h0);
    write_reg(REG_HEADER_SECOND, h1);
    write_reg(REG_HEADER_THIRD, h2);
    write_reg(REG_FRAME_LENGTH, {3'($urandom), len});
    write_reg(REG_HOLD_ON_MISMATCH, {7'($urandom), hold});
    write_reg(RegSpareLo, 8'($urandom));
    write_reg(RegSpareHi, 8'($urandom));
  endtask

  function automatic int unsigned frame_span();
    int unsigned n;
    n = frm_len;
    if (n < 1) n = 1;
    if (n > MaxFrameDefault) n = MaxFrameDefault;
    return n;
  endfunction

  // Sends the rest of a frame from a given position: header bytes, random payload,
  // and a trailing checksum that is broken on request.
  task automatic send_frame_from(input int unsigned start, input logic [7:0] sum_in,
                                 input bit corrupt);
    int unsigned span;
    int unsigned p;
    logic [7:0]  sum;
    logic [7:0]  b;
    span = frame_span();
    sum  = sum_in;
    for (p = start; p < span; p++) begin
      if (p == span - 1) begin
        b = sum;
        if (corrupt) b = b ^ 8'($urandom_range(255, 1));
      end else if (p < hdr_len) begin
        b = hdr_byte[p];
      end else begin
        b = 8'($urandom);
      end
      if (p != span - 1) sum = sum + b;
      send_item(ACT_RECEIVE, b, 4'($urandom));
    end
  endtask

  task automatic after_frame();
    int n;
    n = $urandom_range(3);
    repeat (n) send_item(ACT_READ, 8'($urandom), 4'($urandom));
    if ($urandom_range(99) < 20) send_item(ACT_RECEIVE, 8'($urandom), 4'($urandom));
    if ($urandom_range(99) < 90) send_item(ACT_RELEASE, 8'($urandom), 4'($urandom));
  endtask

  task automatic send_noise();
    int         n;
    logic [7:0] b;
    n = $urandom_range(6, 1);
    repeat (n) begin
      b = ($urandom_range(99) < 25) ? hdr_byte[$urandom_range(2)] : 8'($urandom);
      send_item(2'($urandom), b, 4'($urandom));
    end
  endtask

  // Drains the block, then finishes or releases a frame so the next one starts aligned.
  // A setting where the checksum byte can never pass its header check may stay stuck.
  task automatic realign();
    int tries;
    bit done;
    done = 1'b0;
    for (tries = 0; tries < 4 && !done; tries++) begin
      settle();
      if (pred_held) send_item(ACT_RELEASE, 8'($urandom), 4'($urandom));
      else if (pred_pos != 0) send_frame_from(pred_pos, pred_sum, 1'b0);
      else done = 1'b1;
    end
  endtask

  task automatic run_items(input int unsigned quota);
    int unsigned stop;
    stop = items_sent + quota;
    while (items_sent < stop) begin
      if ($urandom_range(99) < 70) begin
        send_frame_from(0, 8'h00, $urandom_range(99) < 12);
        after_frame();
      end else begin
        send_noise();
        if ($urandom_range(99) < 45) realign();
      end
    end
  endtask

  initial begin
    rst_ni       = 1'b0;
    cfg_valid_i  = 1'b0;
    cfg_index_i  = '0;
    cfg_data_i   = '0;
    in_valid_i   = 1'b0;
    action_i     = ACT_RECEIVE;
    data_byte_i  = '0;
    read_index_i = '0;
    no_gaps      = 1'b0;
    hold_off_req = 1'b0;
    items_sent   = 0;
    hdr_len      = CfgReset.header_length;
    hdr_byte[0]  = CfgReset.header_first;
    hdr_byte[1]  = CfgReset.header_second;
    hdr_byte[2]  = CfgReset.header_third;
    frm_len      = CfgReset.frame_length;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // A full-length good frame first writes every store entry, so any later read is defined.
    apply_setting(2'd3, 8'd64, 8'd94, 8'd118, 5'd16, 1'b0);
    send_frame_from(0, 8'h00, 1'b0);
    send_item(ACT_READ, 8'h00, 4'd0);
    send_item(ACT_READ, 8'hFF, 4'd15);
    send_item(ACT_RECEIVE, 8'hFF, 4'd0);
    send_item(ACT_RELEASE, 8'h00, 4'd0);
    send_item(ACT_RELEASE, 8'h00, 4'd0);
    send_item(ActNone, 8'hFF, 4'd15);
    send_item(ACT_RECEIVE, 8'h00, 4'd0);
    send_item(ACT_RECEIVE, 8'd64, 4'd0);
    send_item(ACT_RECEIVE, 8'h00, 4'd0);

    apply_setting(2'd3, 8'd64, 8'd94, 8'd118, 5'd10, 1'b0);
    run_items(40);
    hold_off_req = 1'b1;
    run_items(PhaseItems - 40);

    apply_setting(2'd3, 8'h00, 8'hFF, 8'h55, 5'd16, 1'b1);
    no_gaps = 1'b1;
    run_items(PhaseItems);
    no_gaps = 1'b0;

    apply_setting(2'd1, 8'hFF, 8'($urandom), 8'($urandom), 5'd4, 1'b0);
    run_items(PhaseItems);

    // Length zero saturates to a one-byte frame.
    apply_setting(2'd0, 8'($urandom), 8'($urandom), 8'($urandom), 5'd0, 1'b0);
    run_items(PhaseItems);

    // The only byte is both header and checksum.
    apply_setting(2'd1, 8'h00, 8'($urandom), 8'($urandom), 5'd1, 1'b1);
    run_items(PhaseItems);

    apply_setting(2'd2, 8'hAA, 8'h55, 8'($urandom), 5'd2, 1'b1);
    run_items(PhaseItems / 2);

    apply_setting(2'd3, 8'($urandom), 8'($urandom), 8'($urandom), 5'd31, 1'b1);
    run_items(PhaseItems);

    apply_setting(2'd2, 8'($urandom), 8'($urandom), 8'($urandom), 5'd17, 1'b0);
    run_items(PhaseItems);

    apply_setting(2'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                  5'($urandom_range(16, 3)), 1'($urandom));
    run_items(PhaseItems);

    settle();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/hcfr_pkg.sv
rtl/core/hcfr_ram.sv
rtl/core/hcfr_cfg.sv
rtl/core/hcfr_ctrl.sv
rtl/core/header_checksum_frame_receiver_unit.sv
verif/hcfr_frame_check.sv
verif/tb_header_checksum_frame_receiver_unit.sv
